// ----- sv/bkr_pkg.sv -----
// Package for the boundary key recombination table.
// Holds field widths, default parameter values and action and mode codes.
// No dependencies.
package bkr_pkg;

    localparam int LM_ORDER_N_DEF    = 3;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int WORD_W   = 20;
    localparam int SCORE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 6;

    typedef logic [WORD_W-1:0]          word_t;
    typedef logic signed [SCORE_W-1:0]  score_t;
    typedef logic [ACTION_W-1:0]        action_t;
    typedef logic [SLOT_W-1:0]          slot_t;

    localparam logic MODE_WORD  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam action_t ACT_ADDED     = 2'd0;
    localparam action_t ACT_REPLACED  = 2'd1;
    localparam action_t ACT_NOT_BEST  = 2'd2;
    localparam action_t ACT_FULL      = 2'd3;

endpackage

// ----- sv/bkr_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module bkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/boundary_key_recombination_table_unit.sv -----
// Top level of the boundary key recombination table.
// Depends on bkr_pkg and on bkr_ram, which holds the key, length and score of each entry.
//
//   channel | signals                                   | direction
//   cand    | mode, word_id, is_last_word, score        | in,  cand_valid / cand_ready
//   res     | action, slot                              | out, res_valid / res_ready
//
// A word beat that is not last, or a clear beat, is taken without leaving the idle state.
// A last word beat scans the stored entries one per cycle through the RAM read port:
// a match ends the scan at that entry, and a miss scans every stored entry before the key
// is added, or reported as full when the table already holds TABLE_ENTRIES entries.
// After reset the table is empty; no clearing pass is needed.
// A finished result waits in the output register while word beats are taken;
// a following search stalls only in its finishing state until that result is taken.
module boundary_key_recombination_table_unit #(
    parameter int LM_ORDER_N    = bkr_pkg::LM_ORDER_N_DEF,
    parameter int TABLE_ENTRIES = bkr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cand_valid,
    output logic            cand_ready,
    input  logic            mode,
    input  bkr_pkg::word_t  word_id,
    input  logic            is_last_word,
    input  bkr_pkg::score_t score,
    output logic            res_valid,
    input  logic            res_ready,
    output bkr_pkg::action_t action,
    output bkr_pkg::slot_t  slot
);

    import bkr_pkg::*;

    localparam int BOUND_LEN = LM_ORDER_N - 1;
    localparam int KEY_MAX   = 2 * BOUND_LEN;
    localparam int LEN_W     = $clog2(KEY_MAX + 1);
    localparam int SEEN_W    = $clog2(KEY_MAX + 2);
    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_BITS  = KEY_MAX * WORD_W;
    localparam int ROW_W     = KEY_BITS + LEN_W + SCORE_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]          state_reg, state_next;
    word_t               head_reg [KEY_MAX];
    word_t               head_next [KEY_MAX];
    word_t               tail_reg [BOUND_LEN];
    word_t               tail_next [BOUND_LEN];
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    score_t              score_reg, score_next;
    action_t             res_action_reg, res_action_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic                res_valid_reg, res_valid_next;
    action_t             action_reg, action_next;
    slot_t               slot_reg, slot_next;

    word_t               head_upd [KEY_MAX];
    word_t               tail_upd [BOUND_LEN];
    logic [SEEN_W-1:0]   seen_upd;
    logic [KEY_BITS-1:0] key_build;
    logic [LEN_W-1:0]    len_build;
    logic                accept;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [ROW_W-1:0]    ram_wr_data;
    logic                ram_rd_en;
    logic [ROW_W-1:0]    ram_rd_data;
    logic                hit;
    logic [IDX_W+SLOT_W-1:0] slot_wide;

    bkr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign cand_ready  = (state_reg == S_IDLE);
    assign accept      = cand_valid && cand_ready;
    assign res_valid   = res_valid_reg;
    assign action      = action_reg;
    assign slot        = slot_reg;
    assign ram_wr_data = {score_reg, len_reg, key_reg};
    assign ram_rd_en   = (state_reg == S_SCAN) && (rd_idx_reg < count_reg);
    assign hit         = pend_reg
                         && (ram_rd_data[KEY_BITS +: LEN_W] == len_reg)
                         && (ram_rd_data[KEY_BITS-1:0] == key_reg);
    assign slot_wide   = {{SLOT_W{1'b0}}, res_idx_reg};

    always_comb
    begin
        for (int i = 0; i < KEY_MAX; i++)
        begin
            head_upd[i] = (seen_reg == SEEN_W'(i)) ? word_id : head_reg[i];
        end
        for (int i = 0; i + 1 < BOUND_LEN; i++)
        begin
            tail_upd[i] = tail_reg[i + 1];
        end
        tail_upd[BOUND_LEN-1] = word_id;
        seen_upd = (seen_reg <= SEEN_W'(KEY_MAX)) ? seen_reg + 1'b1 : seen_reg;

        if (seen_upd > SEEN_W'(KEY_MAX))
        begin
            for (int i = 0; i < BOUND_LEN; i++)
            begin
                key_build[i*WORD_W +: WORD_W]               = head_upd[i];
                key_build[(BOUND_LEN+i)*WORD_W +: WORD_W]   = tail_upd[i];
            end
            len_build = LEN_W'(KEY_MAX);
        end
        else
        begin
            for (int i = 0; i < KEY_MAX; i++)
            begin
                key_build[i*WORD_W +: WORD_W] =
                    (SEEN_W'(i) < seen_upd) ? head_upd[i] : '0;
            end
            len_build = LEN_W'(seen_upd);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        seen_next       = seen_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        score_next      = score_reg;
        res_action_next = res_action_reg;
        res_idx_next    = res_idx_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        action_next     = action_reg;
        slot_next       = slot_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = pend_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_CLEAR)
                    begin
                        count_next = '0;
                        seen_next  = '0;
                        for (int i = 0; i < KEY_MAX; i++)
                        begin
                            head_next[i] = '0;
                        end
                        for (int i = 0; i < BOUND_LEN; i++)
                        begin
                            tail_next[i] = '0;
                        end
                    end
                    else if (is_last_word)
                    begin
                        key_next    = key_build;
                        len_next    = len_build;
                        score_next  = score;
                        rd_idx_next = '0;
                        pend_next   = 1'b0;
                        seen_next   = '0;
                        for (int i = 0; i < KEY_MAX; i++)
                        begin
                            head_next[i] = '0;
                        end
                        for (int i = 0; i < BOUND_LEN; i++)
                        begin
                            tail_next[i] = '0;
                        end
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        head_next = head_upd;
                        tail_next = tail_upd;
                        seen_next = seen_upd;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_idx_next = pend_idx_reg;
                    if (score_reg > $signed(ram_rd_data[KEY_BITS+LEN_W +: SCORE_W]))
                    begin
                        ram_wr_en       = 1'b1;
                        res_action_next = ACT_REPLACED;
                    end
                    else
                    begin
                        res_action_next = ACT_NOT_BEST;
                    end
                    pend_next  = 1'b0;
                    state_next = S_FINISH;
                end
                else if (!pend_reg && (rd_idx_reg == count_reg))
                begin
                    if (count_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = count_reg[IDX_W-1:0];
                        res_idx_next    = count_reg[IDX_W-1:0];
                        res_action_next = ACT_ADDED;
                        count_next      = count_reg + 1'b1;
                    end
                    else
                    begin
                        res_idx_next    = '0;
                        res_action_next = ACT_FULL;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    pend_next = (rd_idx_reg < count_reg);
                    if (rd_idx_reg < count_reg)
                    begin
                        pend_idx_next = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next   = rd_idx_reg + 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    action_next    = res_action_reg;
                    slot_next      = slot_wide[SLOT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seen_reg      <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < KEY_MAX; i++)
            begin
                head_reg[i] <= '0;
            end
            for (int i = 0; i < BOUND_LEN; i++)
            begin
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        score_reg      <= score_next;
        res_action_reg <= res_action_next;
        res_idx_reg    <= res_idx_next;
        action_reg     <= action_next;
        slot_reg       <= slot_next;
    end

endmodule
